// ===== rtl/core/ifb_pkg.sv =====
// Shared constants, codes and types of the IPv4 frame builder.
package ifb_pkg;

  localparam int FRAME_MAX   = 1514;
  localparam int HDR_BYTES   = 34;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  localparam logic [7:0] VER_IHL   = 8'h45;
  localparam logic [7:0] TTL       = 8'd64;
  localparam logic [7:0] BCAST     = 8'hFF;
  localparam logic [7:0] ETYPE_HI  = 8'h08;
  localparam logic [7:0] ETYPE_LO  = 8'h00;
  localparam logic [15:0] IP_HDR_BYTES = 16'd20;

  typedef enum logic [1:0] {
    ENT_HEADER,
    ENT_PAYLOAD,
    ENT_ERROR
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] dest;
    logic [7:0]  proto;
    logic [15:0] total;
    logic [15:0] ident;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/core/ipv4_frame_builder_unit.sv =====
// Top level of the IPv4 frame builder: configuration registers, front end, queue, back end.
// An accepted word is written to the queue at its accepting edge and loaded into the output
// register once the back end pops it, after any header in progress and while not stalled.
// Throughput, while result_stall is low: one payload word per cycle; a start gives a 34-byte
// header, one byte per cycle from the back end serializer; an oversize start, one error word.
// The front end keeps accepting while the four-entry queue has room.
// Reset: identification counter to one, no frame open, queue and output empty, address
// registers to zero; no clearing pass.
module ipv4_frame_builder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic [31:0] dest_address,
  input  logic [7:0]  protocol_number,
  input  logic [15:0] payload_length,
  input  logic [7:0]  payload_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  frame_byte,
  output logic        last_byte,
  output logic        too_long,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);
  import ifb_pkg::*;

  logic [31:0]   own_ip;
  logic [47:0]   own_mac;
  logic          q_push;
  logic          q_pop;
  queue_entry_t  q_in;
  queue_entry_t  q_out;
  queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OWN_IP:  own_ip  <= cfg_data[31:0];
        REG_OWN_MAC: own_mac <= cfg_data;
        default:     own_ip  <= own_ip;
      endcase
    end
  end

  ifb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .dest_address    (dest_address),
    .protocol_number (protocol_number),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .q_status        (q_status),
    .push            (q_push),
    .entry           (q_in)
  );

  ifb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .pop       (q_pop),
    .entry_out (q_out),
    .status    (q_status)
  );

  ifb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .own_ip       (own_ip),
    .own_mac      (own_mac),
    .entry        (q_out),
    .q_status     (q_status),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte),
    .too_long     (too_long)
  );

`ifndef ASSERT_OFF
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (result_valid && too_long) |-> (last_byte && frame_byte == 8'h00))
    else $error("error word without last mark or with nonzero byte");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue write while full");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue read while empty");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> result_valid)
    else $error("queue read without output word");
`endif

endmodule

// ===== rtl/core/ifb_front.sv =====
// Front end: accepts command words, checks frame size, tracks the open frame.
module ifb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  command,
  input  logic [31:0]           dest_address,
  input  logic [7:0]            protocol_number,
  input  logic [15:0]           payload_length,
  input  logic [7:0]            payload_byte,
  input  ifb_pkg::queue_status_t q_status,
  output logic                  push,
  output ifb_pkg::queue_entry_t entry
);
  import ifb_pkg::*;

  logic [15:0] ident;
  logic [15:0] ident_next;
  logic [10:0] bytes_remaining;
  logic [10:0] bytes_remaining_next;
  logic        frame_open;
  logic        frame_open_next;
  logic        accept;
  logic        oversize;

  assign item_stall = q_status.full;
  assign accept     = item_valid && !item_stall;
  assign oversize   = ({1'b0, payload_length} + 17'(HDR_BYTES)) > 17'(FRAME_MAX);

  always_comb begin
    ident_next           = ident;
    bytes_remaining_next = bytes_remaining;
    frame_open_next      = frame_open;
    push                 = 1'b0;
    entry.kind           = ENT_PAYLOAD;
    entry.data           = payload_byte;
    entry.last           = 1'b0;
    entry.dest           = dest_address;
    entry.proto          = protocol_number;
    entry.total          = payload_length + IP_HDR_BYTES;
    entry.ident          = ident;
    if (accept) begin
      unique case (command)
        CMD_START: begin
          frame_open_next      = 1'b0;
          bytes_remaining_next = '0;
          push                 = 1'b1;
          if (oversize) begin
            entry.kind = ENT_ERROR;
            entry.data = '0;
            entry.last = 1'b1;
          end else begin
            entry.kind = ENT_HEADER;
            entry.last = (payload_length == '0);
            ident_next = ident + 16'd1;
            if (payload_length != '0) begin
              bytes_remaining_next = payload_length[10:0];
              frame_open_next      = 1'b1;
            end
          end
        end
        CMD_PAYLOAD: begin
          if (!frame_open || bytes_remaining == '0) begin
            frame_open_next = 1'b0;
          end else begin
            push                 = 1'b1;
            bytes_remaining_next = bytes_remaining - 11'd1;
            entry.last           = (bytes_remaining == 11'd1);
            if (bytes_remaining == 11'd1) begin
              frame_open_next = 1'b0;
            end
          end
        end
        default: begin
          frame_open_next = frame_open;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ident           <= 16'd1;
      bytes_remaining <= '0;
      frame_open      <= 1'b0;
    end else begin
      ident           <= ident_next;
      bytes_remaining <= bytes_remaining_next;
      frame_open      <= frame_open_next;
    end
  end

endmodule

// ===== rtl/core/ifb_queue.sv =====
// Short queue of classified words between front end and back end.
module ifb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ifb_pkg::queue_entry_t  entry_in,
  input  logic                   pop,
  output ifb_pkg::queue_entry_t  entry_out,
  output ifb_pkg::queue_status_t status
);
  import ifb_pkg::*;

  queue_entry_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push_ok;
  logic                pop_ok;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign push_ok      = push && !status.full;
  assign pop_ok       = pop && !status.empty;
  assign entry_out    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ifb_back.sv =====
// Back end: serializes headers with checksum, passes payload and error words, holds the output word.
module ifb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            own_ip,
  input  logic [47:0]            own_mac,
  input  ifb_pkg::queue_entry_t  entry,
  input  ifb_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             frame_byte,
  output logic                   last_byte,
  output logic                   too_long
);
  import ifb_pkg::*;

  localparam logic [5:0]  HDR_LAST_IDX = 6'(HDR_BYTES - 1);
  localparam logic [5:0]  CSUM_LAST_IDX = 6'd6;
  localparam logic [15:0] CSUM_BASE = {VER_IHL, 8'h00} + {TTL, 8'h00};

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + 16'(s[16]);
  endfunction

  logic        advance;
  logic        hdr_active;
  logic [5:0]  hdr_idx;
  logic        hdr_last;
  logic [31:0] job_dest;
  logic [7:0]  job_proto;
  logic [15:0] job_total;
  logic [15:0] job_ident;
  logic [15:0] csum_acc;
  logic [15:0] csum;
  logic [15:0] csum_word;
  logic [7:0]  hdr_byte;

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && !hdr_active && !q_status.empty;
  assign csum    = ~csum_acc;

  always_comb begin
    unique case (hdr_idx)
      6'd1:    csum_word = job_ident;
      6'd2:    csum_word = {8'h00, job_proto};
      6'd3:    csum_word = own_ip[31:16];
      6'd4:    csum_word = own_ip[15:0];
      6'd5:    csum_word = job_dest[31:16];
      6'd6:    csum_word = job_dest[15:0];
      default: csum_word = '0;
    endcase
  end

  always_comb begin
    unique case (hdr_idx)
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5: hdr_byte = BCAST;
      6'd6:    hdr_byte = own_mac[47:40];
      6'd7:    hdr_byte = own_mac[39:32];
      6'd8:    hdr_byte = own_mac[31:24];
      6'd9:    hdr_byte = own_mac[23:16];
      6'd10:   hdr_byte = own_mac[15:8];
      6'd11:   hdr_byte = own_mac[7:0];
      6'd12:   hdr_byte = ETYPE_HI;
      6'd13:   hdr_byte = ETYPE_LO;
      6'd14:   hdr_byte = VER_IHL;
      6'd16:   hdr_byte = job_total[15:8];
      6'd17:   hdr_byte = job_total[7:0];
      6'd18:   hdr_byte = job_ident[15:8];
      6'd19:   hdr_byte = job_ident[7:0];
      6'd22:   hdr_byte = TTL;
      6'd23:   hdr_byte = job_proto;
      6'd24:   hdr_byte = csum[15:8];
      6'd25:   hdr_byte = csum[7:0];
      6'd26:   hdr_byte = own_ip[31:24];
      6'd27:   hdr_byte = own_ip[23:16];
      6'd28:   hdr_byte = own_ip[15:8];
      6'd29:   hdr_byte = own_ip[7:0];
      6'd30:   hdr_byte = job_dest[31:24];
      6'd31:   hdr_byte = job_dest[23:16];
      6'd32:   hdr_byte = job_dest[15:8];
      6'd33:   hdr_byte = job_dest[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      hdr_active   <= 1'b0;
    end else if (advance) begin
      if (hdr_active) begin
        result_valid <= 1'b1;
        frame_byte   <= hdr_byte;
        last_byte    <= hdr_last && (hdr_idx == HDR_LAST_IDX);
        too_long     <= 1'b0;
        hdr_idx      <= hdr_idx + 6'd1;
        if (hdr_idx == HDR_LAST_IDX) begin
          hdr_active <= 1'b0;
        end
        if (hdr_idx <= CSUM_LAST_IDX) begin
          csum_acc <= ones_add(csum_acc, csum_word);
        end
      end else if (!q_status.empty) begin
        result_valid <= 1'b1;
        unique case (entry.kind)
          ENT_HEADER: begin
            frame_byte <= BCAST;
            last_byte  <= 1'b0;
            too_long   <= 1'b0;
            hdr_active <= 1'b1;
            hdr_idx    <= 6'd1;
            hdr_last   <= entry.last;
            job_dest   <= entry.dest;
            job_proto  <= entry.proto;
            job_total  <= entry.total;
            job_ident  <= entry.ident;
            csum_acc   <= ones_add(CSUM_BASE, entry.total);
          end
          ENT_PAYLOAD: begin
            frame_byte <= entry.data;
            last_byte  <= entry.last;
            too_long   <= 1'b0;
          end
          ENT_ERROR: begin
            frame_byte <= 8'h00;
            last_byte  <= 1'b1;
            too_long   <= 1'b1;
          end
          default: begin
            frame_byte <= 8'h00;
            last_byte  <= 1'b0;
            too_long   <= 1'b0;
          end
        endcase
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of ipv4_frame_builder_unit: header prediction, random traffic, scoreboard.
import ifb_pkg::*;

typedef struct {
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       too_long;
} frame_out_t;

class frame_scoreboard;
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] ident;
  logic [10:0] remaining;
  bit          open_frame;
  frame_out_t  expected_bytes[$];
  int          errors;

  function new();
    own_ip     = '0;
    own_mac    = '0;
    ident      = 16'd1;
    remaining  = '0;
    open_frame = 1'b0;
    errors     = 0;
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction

  function void set_address(logic idx, logic [47:0] value);
    if (idx == REG_OWN_IP) begin
      own_ip = value[31:0];
    end else begin
      own_mac = value;
    end
  endfunction

  function void push_byte(logic [7:0] data, logic last, logic err);
    frame_out_t e;
    e.frame_byte = data;
    e.last_byte  = last;
    e.too_long   = err;
    expected_bytes.push_back(e);
  endfunction

  function void note_word(logic cmd, logic [31:0] dst, logic [7:0] proto,
                          logic [15:0] plen, logic [7:0] pbyte);
    logic [15:0] hw [10];
    logic [7:0]  hdr [HDR_BYTES];
    logic [31:0] sum;
    if (cmd == CMD_START) begin
      open_frame = 1'b0;
      remaining  = '0;
      if (HDR_BYTES + plen > FRAME_MAX) begin
        push_byte(8'h00, 1'b1, 1'b1);
        return;
      end
      hw[0] = {VER_IHL, 8'h00};
      hw[1] = IP_HDR_BYTES + plen;
      hw[2] = ident;
      hw[3] = 16'h0000;
      hw[4] = {TTL, proto};
      hw[5] = 16'h0000;
      hw[6] = own_ip[31:16];
      hw[7] = own_ip[15:0];
      hw[8] = dst[31:16];
      hw[9] = dst[15:0];
      sum = '0;
      for (int i = 0; i < 10; i++) sum += hw[i];
      sum = sum[15:0] + sum[31:16];
      sum = sum[15:0] + sum[31:16];
      hw[5] = ~sum[15:0];
      for (int i = 0; i < 6; i++) begin
        hdr[i]     = BCAST;
        hdr[6 + i] = own_mac[47 - 8 * i -: 8];
      end
      hdr[12] = ETYPE_HI;
      hdr[13] = ETYPE_LO;
      for (int i = 0; i < 10; i++) begin
        hdr[14 + 2 * i] = hw[i][15:8];
        hdr[15 + 2 * i] = hw[i][7:0];
      end
      for (int i = 0; i < HDR_BYTES; i++) begin
        push_byte(hdr[i], (i == HDR_BYTES - 1) && (plen == 0), 1'b0);
      end
      ident = ident + 16'd1;
      if (plen != 0) begin
        remaining  = plen[10:0];
        open_frame = 1'b1;
      end
    end else begin
      if (!open_frame || remaining == 0) begin
        open_frame = 1'b0;
        return;
      end
      remaining = remaining - 11'd1;
      if (remaining == 0) open_frame = 1'b0;
      push_byte(pbyte, remaining == 0, 1'b0);
    end
  endfunction

  function void check_byte(logic [7:0] fb, logic lb, logic tl);
    frame_out_t e;
    if (expected_bytes.size() == 0) begin
      $error("frame_byte %0h arrived with nothing expected", fb);
      errors++;
      return;
    end
    e = expected_bytes.pop_front();
    if (fb !== e.frame_byte) begin
      $error("frame_byte: expected %0h, got %0h", e.frame_byte, fb);
      errors++;
    end
    if (lb !== e.last_byte) begin
      $error("last_byte: expected %0b, got %0b", e.last_byte, lb);
      errors++;
    end
    if (tl !== e.too_long) begin
      $error("too_long: expected %0b, got %0b", e.too_long, tl);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 2000000;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        item_valid      = 1'b0;
  logic        item_stall;
  logic        command         = CMD_START;
  logic [31:0] dest_address    = '0;
  logic [7:0]  protocol_number = '0;
  logic [15:0] payload_length  = '0;
  logic [7:0]  payload_byte    = '0;
  logic        result_valid;
  logic        result_stall    = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        too_long;
  logic        cfg_write       = 1'b0;
  logic        cfg_index       = REG_OWN_IP;
  logic [47:0] cfg_data        = '0;

  bit              steady      = 1'b0;
  int              stall_left  = 0;
  int              cycle_count = 0;
  frame_scoreboard sb          = new();

  ipv4_frame_builder_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .dest_address    (dest_address),
    .protocol_number (protocol_number),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .frame_byte      (frame_byte),
    .last_byte       (last_byte),
    .too_long        (too_long),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin : stall_gen
    int gap;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      gap = pick_gap();
      result_stall <= (gap > 0);
      stall_left   <= (gap > 0) ? gap - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_byte(frame_byte, last_byte, too_long);
      if (item_valid && !item_stall) begin
        sb.note_word(command, dest_address, protocol_number, payload_length, payload_byte);
      end
      if (cfg_write) sb.set_address(cfg_index, cfg_data);
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ipv4_frame_builder_unit: mismatch");
      $finish;
    end
  end

  task automatic send_word(logic cmd, logic [31:0] dst, logic [7:0] proto,
                           logic [15:0] plen, logic [7:0] pbyte);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid      <= 1'b1;
    command         <= cmd;
    dest_address    <= dst;
    protocol_number <= proto;
    payload_length  <= plen;
    payload_byte    <= pbyte;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_start(logic [31:0] dst, logic [7:0] proto, logic [15:0] plen);
    send_word(CMD_START, dst, proto, plen, 8'($urandom));
  endtask

  task automatic send_payload(logic [7:0] pbyte);
    send_word(CMD_PAYLOAD, $urandom, 8'($urandom), 16'($urandom), pbyte);
  endtask

  task automatic finish_phase();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_addresses(logic [31:0] ip, logic [47:0] mac);
    cfg_write <= 1'b1;
    cfg_index <= REG_OWN_IP;
    cfg_data  <= {16'h0000, ip};
    @(posedge clk);
    cfg_index <= REG_OWN_MAC;
    cfg_data  <= mac;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_frames(int n);
    int sent;
    int pick;
    int plen;
    int count;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) plen = 0;
        else if (pick < 70) plen = $urandom_range(1, 16);
        else if (pick < 95) plen = $urandom_range(17, 64);
        else plen = $urandom_range(65, 300);
        send_start($urandom, 8'($urandom), 16'(plen));
        count = plen;
        if (plen > 1 && $urandom_range(0, 9) == 0) count = $urandom_range(1, plen - 1);
        repeat (count) send_payload(8'($urandom));
        sent += 1 + count;
        if ($urandom_range(0, 9) == 0) begin
          send_payload(8'($urandom));
          sent++;
        end
      end else if (pick < 90) begin
        plen = ($urandom_range(0, 3) == 0) ? FRAME_MAX - HDR_BYTES + 1
                                           : $urandom_range(FRAME_MAX - HDR_BYTES + 1, 65535);
        send_start($urandom, 8'($urandom), 16'(plen));
        sent++;
      end else begin
        count = $urandom_range(1, 3);
        repeat (count) send_payload(8'($urandom));
        sent += count;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    load_addresses(32'h0000_0000, 48'h0000_0000_0000);
    send_payload(8'hA5);
    send_start(32'h0000_0000, 8'h00, 16'd0);
    send_start(32'hFFFF_FFFF, 8'hFF, 16'd1);
    send_payload(8'hFF);
    send_payload(8'h00);
    send_start(32'h1234_5678, 8'h11, 16'(FRAME_MAX - HDR_BYTES + 1));
    send_start(32'h8765_4321, 8'h06, 16'hFFFF);
    finish_phase();

    load_addresses(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_start(32'h0A00_0001, 8'h06, 16'(FRAME_MAX - HDR_BYTES));
    send_payload(8'h01);
    send_payload(8'h80);
    send_payload(8'h7F);
    send_start(32'hC0A8_0001, 8'h11, 16'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);
    send_start(32'h5555_AAAA, 8'h01, 16'h8000);
    send_start(32'hAAAA_5555, 8'h01, 16'd2);
    send_payload(8'h3C);
    send_payload(8'hC3);
    finish_phase();

    load_addresses($urandom, {16'($urandom), 32'($urandom)});
    run_frames(90);
    finish_phase();

    steady = 1'b1;
    load_addresses($urandom, {16'($urandom), 32'($urandom)});
    run_frames(90);
    finish_phase();

    steady = 1'b0;
    load_addresses($urandom, {16'($urandom), 32'($urandom)});
    run_frames(90);
    finish_phase();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ipv4_frame_builder_unit: match");
    end else begin
      $display("ipv4_frame_builder_unit: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/ifb_pkg.sv
rtl/core/ifb_front.sv
rtl/core/ifb_queue.sv
rtl/core/ifb_back.sv
rtl/core/ipv4_frame_builder_unit.sv
tb/sv/tb_top.sv
